// ===== rtl/core/lcdbg_pkg.sv =====
package lcdbg_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lcd_mode_t;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] REG_SCROLL_Y     = 2'd0;
    localparam logic [1:0] REG_SCROLL_X     = 2'd1;
    localparam logic [1:0] REG_BG_PALETTE   = 2'd2;
    localparam logic [1:0] REG_LINE_COMPARE = 2'd3;

    localparam logic [9:0] OAM_DOTS  = 10'd80;
    localparam logic [9:0] XFER_DOTS = 10'd172;
    localparam logic [9:0] HBL_DOTS  = 10'd204;
    localparam logic [9:0] VBL_DOTS  = 10'd456;
    localparam logic [7:0] LAST_LINE = 8'd153;
    localparam logic [9:0] CLOCK_MAX = 10'd1023;
    localparam logic [12:0] MAP_OFFSET = 13'h1800;

    // Entry of the queue between the front and the back part.
    typedef struct packed {
        logic       render;
        logic [7:0] line;
        lcd_mode_t  mode;
        logic       coincidence;
    } job_t;

    typedef enum logic [2:0] {
        RS_IDLE,
        RS_MAP,
        RS_LO,
        RS_HI,
        RS_SHADE,
        RS_EMIT
    } rstate_t;

endpackage

// ===== rtl/core/lcdbg_timer.sv =====
module lcdbg_timer
    import lcdbg_pkg::*;
#(
    parameter int VISIBLE_LINES = 144
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] cycles,
    input  logic [7:0] line_compare,
    output job_t       job
);

    lcd_mode_t  mode_reg, mode_next;
    logic [9:0] clock_reg, clock_next;
    logic [7:0] line_reg, line_next;
    logic [10:0] sum;
    logic [9:0] sat;
    logic [7:0] inc;
    logic       render;

    always_comb
    begin
        sum = {1'b0, clock_reg} + {3'b0, cycles};
        sat = sum[10] ? CLOCK_MAX : sum[9:0];
        inc = line_reg + 8'd1;
        mode_next = mode_reg;
        clock_next = sat;
        line_next = line_reg;
        render = 1'b0;
        unique case (mode_reg)
            MODE_OAM:
                if (sat >= OAM_DOTS)
                begin
                    clock_next = sat - OAM_DOTS;
                    mode_next = MODE_XFER;
                end
            MODE_XFER:
                if (sat >= XFER_DOTS)
                begin
                    clock_next = sat - XFER_DOTS;
                    mode_next = MODE_HBLANK;
                    render = 1'b1;
                end
            MODE_HBLANK:
                if (sat >= HBL_DOTS)
                begin
                    clock_next = sat - HBL_DOTS;
                    line_next = inc;
                    mode_next = ({24'b0, inc} >= VISIBLE_LINES) ? MODE_VBLANK : MODE_OAM;
                end
            default:
                if (sat >= VBL_DOTS)
                begin
                    clock_next = sat - VBL_DOTS;
                    line_next = inc;
                    if (inc >= LAST_LINE)
                    begin
                        line_next = 8'd0;
                        mode_next = MODE_OAM;
                    end
                end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OAM;
            clock_reg <= 10'd0;
            line_reg <= 8'd0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            clock_reg <= clock_next;
            line_reg <= line_next;
        end
    end

    // Job fields describe the state after this tick.
    assign job.render = render;
    assign job.line = line_next;
    assign job.mode = mode_next;
    assign job.coincidence = (line_next == line_compare);

endmodule

// ===== rtl/core/lcdbg_render.sv =====
module lcdbg_render
    import lcdbg_pkg::*;
#(
    parameter int LINE_PIXELS = 160,
    parameter int GW = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  job_t          job,
    input  logic [7:0]    scroll_y,
    input  logic [7:0]    scroll_x,
    input  logic [7:0]    bg_palette,
    output logic [12:0]   rd_addr,
    input  logic [7:0]    rd_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [39:0]   out_data,
    output logic          out_last
);

    localparam int GROUPS = (LINE_PIXELS + 7) / 8;
    localparam logic [GW-1:0] LAST_G = GW'(GROUPS - 1);

    rstate_t       st_reg, st_next;
    job_t          job_reg;
    logic [GW-1:0] grp_reg;
    logic [2:0]    pix_reg;
    logic [15:0]   sh_reg;
    logic [7:0]    tile_reg, lo_reg;
    logic [7:0]    py, px;
    logic [8:0]    xpos;
    logic [2:0]    bitn;
    logic [1:0]    ci;
    logic [1:0]    shade;
    logic          pix_in;
    logic          ob_valid_reg;
    logic [39:0]   ob_data_reg;
    logic          ob_last_reg;
    logic          ob_free;

    assign ob_free = !ob_valid_reg || out_ready;
    assign py = job_reg.line + scroll_y;
    assign xpos = {1'b0, grp_reg, pix_reg} & 9'h1FF;
    assign px = xpos[7:0] + scroll_x;
    assign bitn = 3'd7 - px[2:0];
    assign ci = {rd_data[bitn], lo_reg[bitn]};
    assign shade = bg_palette[{ci, 1'b0} +: 2];
    assign pix_in = ({23'b0, xpos} < LINE_PIXELS);

    // Read data arrives in the cycle after its address, so the tile number read in
    // the map step addresses the low plane directly from the read port.
    always_comb
    begin
        rd_addr = MAP_OFFSET + {3'b0, py[7:3], px[7:3]};
        unique case (st_reg)
            RS_LO:   rd_addr = {1'b0, rd_data, py[2:0], 1'b0};
            RS_HI:   rd_addr = {1'b0, tile_reg, py[2:0], 1'b1};
            default: rd_addr = MAP_OFFSET + {3'b0, py[7:3], px[7:3]};
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        job_ready = 1'b0;
        unique case (st_reg)
            RS_IDLE:
                if (job_valid && ob_free)
                begin
                    job_ready = 1'b1;
                    st_next = job.render ? RS_MAP : RS_EMIT;
                end
            RS_MAP:   st_next = RS_LO;
            RS_LO:    st_next = RS_HI;
            RS_HI:    st_next = RS_SHADE;
            RS_SHADE: st_next = (pix_reg == 3'd7) ? RS_EMIT : RS_MAP;
            RS_EMIT:
                if (ob_free)
                    st_next = (!job_reg.render || grp_reg == LAST_G) ? RS_IDLE : RS_MAP;
            default: st_next = RS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= RS_IDLE;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_ready)
                ob_valid_reg <= 1'b0;
            if (st_reg == RS_EMIT && ob_free)
                ob_valid_reg <= 1'b1;
        end
    end

    // Pixel reads go map, low plane, high plane, then the shade is formed:
    // three reads per pixel.
    always_ff @(posedge clk)
    begin
        if (st_reg == RS_IDLE && job_ready)
        begin
            job_reg <= job;
            grp_reg <= '0;
            pix_reg <= 3'd0;
            sh_reg <= 16'd0;
        end
        if (st_reg == RS_LO)
            tile_reg <= rd_data;
        if (st_reg == RS_HI)
            lo_reg <= rd_data;
        if (st_reg == RS_SHADE)
        begin
            if (pix_in)
                sh_reg[{pix_reg, 1'b0} +: 2] <= shade;
            pix_reg <= pix_reg + 3'd1;
        end
        if (st_reg == RS_EMIT && ob_free)
        begin
            ob_data_reg <= {7'b0, job_reg.coincidence, job_reg.mode, job_reg.line,
                            job_reg.render ? sh_reg : 16'd0,
                            job_reg.render ? grp_reg : GW'(0), job_reg.render};
            ob_last_reg <= !job_reg.render || grp_reg == LAST_G;
            grp_reg <= grp_reg + GW'(1);
            sh_reg <= 16'd0;
        end
    end

    assign out_valid = ob_valid_reg;
    assign out_data = ob_data_reg;
    assign out_last = ob_last_reg;

    property p_last_status;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data[0]) |-> out_last;
    endproperty
    assert property (p_last_status) else $error("status item without last");

    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data);
    endproperty
    assert property (p_hold) else $error("output changed while stalled");

    property p_idle_take;
        @(posedge clk) disable iff (!rst_n)
        job_ready |-> st_reg == RS_IDLE;
    endproperty
    assert property (p_idle_take) else $error("job taken while busy");

endmodule

// ===== rtl/core/lcd_mode_timer_bg_line_render.sv =====
// Channel  | Direction | Handshake             | Content
// s_axis   | in        | s_axis_tvalid/tready  | tdata: cycles, vram_address, vram_data; tuser: command
// m_axis   | out       | m_axis_tvalid/tready  | tdata: result fields; tlast: last
// cfg      | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A write or a plain tick shows its status item through the job queue, the renderer's idle
// and emit states and the output register when it is free; a stalled output adds its stall.
// A tick that ends transfer renders the line: three video memory reads and a shade
// step per pixel (map, low plane, high plane) through one registered read port, and
// an emit step per group.
// New input items wait while a render is pending, so later writes cannot change the
// line being drawn; the input reopens once the last group has been taken.
// No clearing pass after reset; the video memory is undefined until written.
// The front timer hands jobs to the renderer through a two-entry queue; each side
// stalls on its own, and the output register holds an item until it is taken.
module lcd_mode_timer_bg_line_render
    import lcdbg_pkg::*;
#(
    parameter int LINE_PIXELS = 160,
    parameter int VISIBLE_LINES = 144
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // cycles[7:0], vram_address[20:8], vram_data[28:21]
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // pixels_valid, pixel_group, shades, current_line,
                                        // mode, coincidence, from bit 0 up
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int GW = 5;

    logic [7:0] scroll_y_reg, scroll_x_reg, bg_palette_reg, line_compare_reg;
    logic [7:0] vram [8192];
    logic [12:0] rd_addr;
    logic [7:0]  rd_data_reg;
    job_t        job_new, q_head;
    job_t        q_mem [2];
    logic        q_wp_reg, q_rp_reg;
    logic [1:0]  q_cnt_reg;
    logic        q_push, q_pop, q_ready;
    logic        accept, is_write;
    logic [39:0] rdata;
    job_t        tjob;
    logic        render_pend_reg;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = (q_cnt_reg != 2'd2) && !render_pend_reg;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign is_write = (s_axis_tuser == CMD_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_y_reg <= 8'd0;
            scroll_x_reg <= 8'd0;
            bg_palette_reg <= 8'd252;
            line_compare_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCROLL_Y:     scroll_y_reg <= cfg_data;
                REG_SCROLL_X:     scroll_x_reg <= cfg_data;
                REG_BG_PALETTE:   bg_palette_reg <= cfg_data;
                REG_LINE_COMPARE: line_compare_reg <= cfg_data;
                default:          scroll_y_reg <= scroll_y_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_write)
            vram[s_axis_tdata[20:8]] <= s_axis_tdata[28:21];
        rd_data_reg <= vram[rd_addr];
    end

    lcdbg_timer #(.VISIBLE_LINES(VISIBLE_LINES)) u_timer (
        .clk(clk), .rst_n(rst_n), .step(accept && !is_write),
        .cycles(s_axis_tdata[7:0]), .line_compare(line_compare_reg), .job(tjob)
    );

    // A write leaves timing alone; its status shows the current state.
    always_comb
    begin
        job_new = tjob;
        if (is_write)
        begin
            job_new.render = 1'b0;
            job_new.line = u_timer.line_reg;
            job_new.mode = u_timer.mode_reg;
            job_new.coincidence = (u_timer.line_reg == line_compare_reg);
        end
    end

    // Set when a render job enters the queue, cleared when its last group leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            render_pend_reg <= 1'b0;
        else if (accept && job_new.render)
            render_pend_reg <= 1'b1;
        else if (m_axis_tvalid && m_axis_tready && m_axis_tlast && rdata[0])
            render_pend_reg <= 1'b0;
    end

    assign q_push = accept;
    assign q_head = q_mem[q_rp_reg];

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_wp_reg] <= job_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg <= 1'b0;
            q_rp_reg <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            if (q_push) q_wp_reg <= ~q_wp_reg;
            if (q_pop)  q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, q_pop};
        end
    end

    assign q_pop = q_ready && (q_cnt_reg != 2'd0);

    lcdbg_render #(.LINE_PIXELS(LINE_PIXELS), .GW(GW)) u_render (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_cnt_reg != 2'd0), .job_ready(q_ready), .job(q_head),
        .scroll_y(scroll_y_reg), .scroll_x(scroll_x_reg), .bg_palette(bg_palette_reg),
        .rd_addr(rd_addr), .rd_data(rd_data_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(rdata), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = rdata;

    property p_q_bound;
        @(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 2'd2;
    endproperty
    assert property (p_q_bound) else $error("job queue overflow");

    property p_no_push_full;
        @(posedge clk) disable iff (!rst_n)
        (q_cnt_reg == 2'd2) |-> !q_push;
    endproperty
    assert property (p_no_push_full) else $error("push into full queue");

    property p_pop_nonempty;
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> q_cnt_reg != 2'd0;
    endproperty
    assert property (p_pop_nonempty) else $error("pop from empty queue");

    property p_render_blocks;
        @(posedge clk) disable iff (!rst_n)
        render_pend_reg |-> !accept;
    endproperty
    assert property (p_render_blocks) else $error("input taken during render");

endmodule
